### rtl/decaying_sine_voice_top_defines.svh
// assertion macros for the decaying sine voice
// used by decaying_sine_voice_top, expects clk_i and rst_ni in scope
`ifndef DECAYING_SINE_VOICE_TOP_DEFINES_SVH
`define DECAYING_SINE_VOICE_TOP_DEFINES_SVH

// property checked at every clock edge outside reset
`define DSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked with the non-overlapping |=> operator
`define DSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dsv_pkg.sv
// shared constants for the decaying sine voice
// no dependencies
`timescale 1ns / 1ps

package dsv_pkg;

  localparam int unsigned SINE_INDEX_BITS_DEF = 10;
  localparam int unsigned PHASE_BITS_DEF      = 32;

  // configuration register indexes
  localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL    = 2'd1;
  localparam logic [1:0] REG_DECAY_FACTOR = 2'd2;
  localparam logic [1:0] REG_DECAY_FLOOR  = 2'd3;

  // reset values of the configuration registers
  localparam logic [31:0] PHASE_STEP_RST   = 32'd78741116;
  localparam logic [15:0] MAX_LEVEL_RST    = 16'd6554;
  localparam logic [23:0] DECAY_FACTOR_RST = 24'd16775539;
  localparam logic [23:0] DECAY_FLOOR_RST  = 24'd84;

  // action codes
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_TRIGGER = 1'b1;

  // sine polynomial coefficients in q16
  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [15:0] POLY_B = 16'd42047;
  localparam logic [12:0] POLY_C = 13'd4640;

  // full scale amplitude in q1.23
  localparam logic signed [24:0] AMP_FULL     = 25'sd8388608;
  localparam logic signed [32:0] AMP_FULL_EXT = 33'sd8388608;

  localparam logic [14:0] SINE_MAX = 15'h7fff;

endpackage

### rtl/decaying_sine_voice_top.sv
// decaying sine voice: triggered sine tone with exponential amplitude decay
// depends on dsv_pkg and decaying_sine_voice_top_defines.svh
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid_i, in_stall_o, action_i,        | input
//            | trigger_factor_i                         |
//   out      | out_valid_o, out_stall_i, sample_o       | output
//   cfg      | cfg_we_i, cfg_index_i, cfg_data_i        | input
//
// one item per cycle while the output is not stalled; a tick sample passes stages 1 to 4 and then the output register
// amplitude and phase are updated at the input transfer, the sine polynomial
// runs through four multiplier stages and the amplitude product fills the output register
// each stage moves on when the next one is empty or moving, so bubbles collapse
// a trigger gives no sample and only loads the amplitude
// reset clears phase, amplitude and stage valid bits and loads register defaults
`timescale 1ns / 1ps
`include "decaying_sine_voice_top_defines.svh"

module decaying_sine_voice_top #(
  parameter int unsigned SINE_INDEX_BITS = dsv_pkg::SINE_INDEX_BITS_DEF,
  parameter int unsigned PHASE_BITS      = dsv_pkg::PHASE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [23:0] trigger_factor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o
);

  localparam int unsigned QBITS = SINE_INDEX_BITS - 2;

  // configuration
  logic [PHASE_BITS-1:0] phase_step_q;
  logic [15:0]           max_level_q;
  logic [23:0]           decay_factor_q;
  logic [23:0]           decay_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= dsv_pkg::PHASE_STEP_RST[PHASE_BITS-1:0];
      max_level_q    <= dsv_pkg::MAX_LEVEL_RST;
      decay_factor_q <= dsv_pkg::DECAY_FACTOR_RST;
      decay_floor_q  <= dsv_pkg::DECAY_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dsv_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data_i[PHASE_BITS-1:0];
        dsv_pkg::REG_MAX_LEVEL:    max_level_q    <= cfg_data_i[15:0];
        dsv_pkg::REG_DECAY_FACTOR: decay_factor_q <= cfg_data_i[23:0];
        dsv_pkg::REG_DECAY_FLOOR:  decay_floor_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic in_xfer, tick_xfer, trig_xfer;

  assign rdy_out = !out_v_q || !out_stall_i;
  assign rdy4    = !v4_q || rdy_out;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;

  assign in_stall_o = !rdy1;
  assign in_xfer    = in_valid_i && rdy1;
  assign tick_xfer  = in_xfer && (action_i == dsv_pkg::ACT_TICK);
  assign trig_xfer  = in_xfer && (action_i == dsv_pkg::ACT_TRIGGER);

  // voice state
  logic [PHASE_BITS-1:0] phase_acc_q;
  logic signed [24:0]    amp_q, amp_d;

  // trigger amplitude
  logic signed [40:0] trig_prod;
  logic signed [32:0] trig_shift;
  logic signed [24:0] trig_amp;

  assign trig_prod  = $signed({{17{trigger_factor_i[23]}}, trigger_factor_i})
                    * $signed({25'd0, max_level_q});
  assign trig_shift = trig_prod[40:8];

  always_comb begin
    if (trig_shift > dsv_pkg::AMP_FULL_EXT) begin
      trig_amp = dsv_pkg::AMP_FULL;
    end else if (trig_shift < -dsv_pkg::AMP_FULL_EXT) begin
      trig_amp = -dsv_pkg::AMP_FULL;
    end else begin
      trig_amp = trig_shift[24:0];
    end
  end

  // decay
  logic [47:0] decay_prod;
  logic        above_floor;

  assign decay_prod  = amp_q[23:0] * decay_factor_q;
  assign above_floor = amp_q > $signed({1'b0, decay_floor_q});

  always_comb begin
    amp_d = amp_q;
    if (trig_xfer) begin
      amp_d = trig_amp;
    end else if (tick_xfer && above_floor) begin
      amp_d = $signed({1'b0, decay_prod[47:24]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      amp_q       <= '0;
    end else begin
      amp_q <= amp_d;
      if (tick_xfer) begin
        phase_acc_q <= phase_acc_q + phase_step_q;
      end
    end
  end

  // sine front end: quadrant, folded offset, x squared
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QBITS-1:0]           r_raw;
  logic [QBITS:0]             r_fold;
  logic [16:0]                x0;
  logic [33:0]                xsq_prod;

  assign idx      = phase_acc_q[PHASE_BITS-1 -: SINE_INDEX_BITS];
  assign quad     = idx[SINE_INDEX_BITS-1 -: 2];
  assign r_raw    = idx[QBITS-1:0];
  assign r_fold   = quad[0] ? ({1'b1, {QBITS{1'b0}}} - {1'b0, r_raw}) : {1'b0, r_raw};
  assign x0       = 17'(r_fold) << (16 - QBITS);
  assign xsq_prod = x0 * x0;

  // stage 1
  logic [1:0]         quad1_q;
  logic [16:0]        x1_q, xsq1_q;
  logic signed [24:0] amp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= tick_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      quad1_q <= quad;
      x1_q    <= x0;
      xsq1_q  <= xsq_prod[32:16];
      amp1_q  <= amp_q;
    end
  end

  // stage 2: c times x squared
  logic [29:0]        t_prod;
  logic [1:0]         quad2_q;
  logic [16:0]        x2_q, xsq2_q;
  logic [12:0]        t2_q;
  logic signed [24:0] amp2_q;

  assign t_prod = dsv_pkg::POLY_C * xsq1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      quad2_q <= quad1_q;
      x2_q    <= x1_q;
      xsq2_q  <= xsq1_q;
      t2_q    <= t_prod[28:16];
      amp2_q  <= amp1_q;
    end
  end

  // stage 3: x squared times (b - t)
  logic [15:0]        bmt;
  logic [32:0]        u_prod;
  logic [1:0]         quad3_q;
  logic [16:0]        x3_q;
  logic [15:0]        u3_q;
  logic signed [24:0] amp3_q;

  assign bmt    = dsv_pkg::POLY_B - {3'd0, t2_q};
  assign u_prod = xsq2_q * bmt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      quad3_q <= quad2_q;
      x3_q    <= x2_q;
      u3_q    <= u_prod[31:16];
      amp3_q  <= amp2_q;
    end
  end

  // stage 4: x times (a - u), halve, clamp, sign by quadrant
  logic [16:0]        amu;
  logic [33:0]        y_prod;
  logic [15:0]        y_half;
  logic [14:0]        sine_mag;
  logic signed [15:0] sine;
  logic signed [15:0] sine4_q;
  logic signed [24:0] amp4_q;

  assign amu      = dsv_pkg::POLY_A - {1'b0, u3_q};
  assign y_prod   = x3_q * amu;
  assign y_half   = y_prod[32:17];
  assign sine_mag = (y_half > {1'b0, dsv_pkg::SINE_MAX}) ? dsv_pkg::SINE_MAX : y_half[14:0];
  assign sine     = quad3_q[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      sine4_q <= sine;
      amp4_q  <= amp3_q;
    end
  end

  // output: amplitude times sine, floor shift by 23
  logic signed [40:0] s_prod;
  logic signed [15:0] sample_q;

  assign s_prod = $signed({{16{amp4_q[24]}}, amp4_q})
                * $signed({{25{sine4_q[15]}}, sine4_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_out) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && v4_q) begin
      sample_q <= s_prod[38:23];
    end
  end

  assign out_valid_o = out_v_q;
  assign sample_o    = sample_q;

  // checks
  `DSV_ASSERT(a_amp_range, (amp_q <= dsv_pkg::AMP_FULL) && (amp_q >= -dsv_pkg::AMP_FULL), "amplitude out of range")
  `DSV_ASSERT_NEXT(a_decay_no_rise, tick_xfer && (amp_q > 25'sd0), amp_q <= $past(amp_q), "decay raised amplitude")
  `DSV_ASSERT_NEXT(a_phase_hold, !tick_xfer, $stable(phase_acc_q), "phase moved without a tick transfer")
  `DSV_ASSERT_NEXT(a_no_phantom_out, !v4_q && !out_v_q, !out_v_q, "sample without a pipeline item")

endmodule

### sim/decaying_sine_voice_top_tb.sv
// self-checking testbench for decaying_sine_voice_top: directed and random voices
// depends on dsv_pkg and the rtl of decaying_sine_voice_top; has its own sample predictor
`timescale 1ns / 1ps

module decaying_sine_voice_top_tb;
  import dsv_pkg::*;

  localparam int SIN_BITS     = SINE_INDEX_BITS_DEF;
  localparam int PH_BITS      = PHASE_BITS_DEF;
  localparam int QBITS        = SIN_BITS - 2;
  localparam int DRAIN_CYCLES = 12;

  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall_o;
  logic               action;
  logic signed [23:0] trigger_factor;
  logic               out_valid_o;
  logic               out_stall;
  logic signed [15:0] sample_o;

  // predictor state and register copies
  logic [31:0]        reg_phase_step;
  logic [15:0]        reg_max_level;
  logic [23:0]        reg_decay_factor;
  logic [23:0]        reg_decay_floor;
  logic [31:0]        phase_acc_m;
  logic signed [24:0] amp_m;

  logic signed [15:0] expected_samples[$];
  int unsigned        mismatches;
  int                 stall_mode;
  int                 hold_cycles;
  int                 gap_max;
  int                 burst_left;

  decaying_sine_voice_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .action_i        (action),
    .trigger_factor_i(trigger_factor),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .sample_o        (sample_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [15:0] sine_lookup(input logic [31:0] ph);
    logic [63:0] idx, r, x, x2, t, y;
    logic signed [15:0] s;
    idx = 64'(ph) >> (PH_BITS - SIN_BITS);
    r = idx & ((64'd1 << QBITS) - 64'd1);
    if (idx[QBITS]) begin
      r = (64'd1 << QBITS) - r;
    end
    x  = r << (16 - QBITS);
    x2 = (x * x) >> 16;
    t  = (64'(POLY_C) * x2) >> 16;
    t  = (x2 * (64'(POLY_B) - t)) >> 16;
    y  = (x * (64'(POLY_A) - t)) >> 16;
    y  = y >> 1;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    s = y[15:0];
    if (idx[QBITS+1]) begin
      s = -s;
    end
    return s;
  endfunction

  // updates amplitude and phase for one accepted transfer, queues the sample of a tick
  task automatic advance_voice(input logic act, input logic signed [23:0] fac);
    logic signed [47:0] prod;
    logic [63:0]        shrunk;
    if (act == ACT_TRIGGER) begin
      prod = fac * $signed({1'b0, reg_max_level});
      prod = prod >>> 8;
      if (prod > 48'sd8388608) begin
        prod = 48'sd8388608;
      end else if (prod < -48'sd8388608) begin
        prod = -48'sd8388608;
      end
      amp_m = prod[24:0];
    end else begin
      prod = amp_m * sine_lookup(phase_acc_m);
      prod = prod >>> 23;
      expected_samples.push_back(prod[15:0]);
      phase_acc_m = phase_acc_m + reg_phase_step;
      if (amp_m > $signed({1'b0, reg_decay_floor})) begin
        shrunk = 64'(amp_m[23:0]) * 64'(reg_decay_factor);
        amp_m  = 25'(shrunk >> 24);
      end
    end
  endtask

  // receiver: own stall pattern plus a long hold-off when requested
  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
          STALL_PATTERN: out_stall <= ((cyc % 13) < 5) || ((cyc % 7) == 3);
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(negedge clk_i) begin : sample_check
    logic signed [15:0] want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected sample %0d at %0t", sample_o, $time);
        end
      end else begin
        want = expected_samples.pop_front();
        if (sample_o !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample mismatch: expected %0d, got %0d at %0t", want, sample_o, $time);
          end
        end
      end
    end
  end

  task automatic send_item(input logic act, input logic signed [23:0] fac);
    bit ok;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    action         <= act;
    trigger_factor <= fac;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    advance_voice(act, fac);
  endtask

  task automatic drain_voice;
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_voice(input logic [31:0] step, input logic [15:0] level,
                               input logic [23:0] decay, input logic [23:0] floor_amp);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_data  <= step;
    @(posedge clk_i);
    reg_phase_step = step;
    cfg_index <= REG_MAX_LEVEL;
    cfg_data  <= 32'(level);
    @(posedge clk_i);
    reg_max_level = level;
    cfg_index <= REG_DECAY_FACTOR;
    cfg_data  <= 32'(decay);
    @(posedge clk_i);
    reg_decay_factor = decay;
    cfg_index <= REG_DECAY_FLOOR;
    cfg_data  <= 32'(floor_amp);
    @(posedge clk_i);
    reg_decay_floor = floor_amp;
    cfg_we <= 1'b0;
  endtask

  // reset register values; tick before any trigger, unit and extreme factors
  task automatic test_default_registers;
    send_item(ACT_TICK, 24'sd0);
    send_item(ACT_TRIGGER, 24'sd65536);
    repeat (4) send_item(ACT_TICK, -24'sd1);
    send_item(ACT_TRIGGER, -24'sd8388608);
    repeat (3) send_item(ACT_TICK, 24'sd0);
    send_item(ACT_TRIGGER, 24'sd8388607);
    repeat (2) send_item(ACT_TICK, 24'sd0);
    send_item(ACT_TRIGGER, 24'sd0);
    send_item(ACT_TICK, 24'sd0);
    drain_voice();
  endtask

  // saturation, wrap of the phase, full and zero decay, quadrant boundaries
  task automatic test_register_extremes;
    program_voice(32'hffff_ffff, 16'd32768, 24'd0, 24'd0);
    send_item(ACT_TRIGGER, 24'sd8388607);
    repeat (3) send_item(ACT_TICK, 24'sd0);
    drain_voice();
    program_voice(32'h4000_0000, 16'd1, 24'hff_ffff, 24'd8388608);
    send_item(ACT_TRIGGER, -24'sd1);
    repeat (4) send_item(ACT_TICK, 24'sd0);
    send_item(ACT_TRIGGER, 24'sd16777);
    repeat (4) send_item(ACT_TICK, 24'sd0);
    drain_voice();
  endtask

  task automatic test_random_voices;
    int sent;
    int n;
    logic signed [23:0] fac;
    for (int round = 0; round < 8; round++) begin
      if (round == 0) begin
        program_voice(32'd0, 16'd0, 24'd0, 24'd0);
      end else if (round == 1) begin
        program_voice(32'hffff_ffff, 16'd32768, 24'hff_ffff, 24'd8388608);
      end else begin
        program_voice($urandom, 16'($urandom_range(0, 32768)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                  : 24'($urandom_range(16500000, 16777215)),
                      ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 500))
                                                  : 24'($urandom_range(0, 8388608)));
      end
      stall_mode = round % 3;
      case (round % 4)
        0:       gap_max = 0;
        1:       gap_max = 3;
        2:       gap_max = 8;
        default: gap_max = 1;
      endcase
      sent = 0;
      while (sent < 125) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'($urandom_range(0, 1)), 24'($urandom));
          sent++;
        end else begin
          case ($urandom_range(0, 2))
            0:       fac = 24'($urandom);
            1:       fac = 24'($urandom_range(0, 196608));
            default: fac = 24'(-int'($urandom_range(1, 196608)));
          endcase
          send_item(ACT_TRIGGER, fac);
          n = $urandom_range(1, 24);
          repeat (n) send_item(ACT_TICK, 24'($urandom));
          sent += n + 1;
        end
      end
      drain_voice();
    end
  endtask

  // output held off for a long stretch while transfers keep coming
  task automatic test_input_backpressure;
    program_voice($urandom, 16'($urandom_range(0, 32768)),
                  24'($urandom_range(16600000, 16777215)), 24'($urandom_range(0, 300)));
    stall_mode  = STALL_NONE;
    gap_max     = 0;
    hold_cycles = 150;
    send_item(ACT_TRIGGER, 24'($urandom_range(0, 131072)));
    repeat (60) send_item(ACT_TICK, 24'($urandom));
    stall_mode  = STALL_RANDOM;
    hold_cycles = 80;
    send_item(ACT_TRIGGER, 24'(-int'($urandom_range(1, 131072))));
    repeat (40) send_item(ACT_TICK, 24'($urandom));
    drain_voice();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_PHASE_STEP;
    cfg_data       = 32'd0;
    in_valid       = 1'b0;
    action         = ACT_TICK;
    trigger_factor = 24'sd0;
    mismatches     = 0;
    stall_mode     = STALL_NONE;
    hold_cycles    = 0;
    gap_max        = 0;
    burst_left     = 0;
    reg_phase_step   = PHASE_STEP_RST;
    reg_max_level    = MAX_LEVEL_RST;
    reg_decay_factor = DECAY_FACTOR_RST;
    reg_decay_floor  = DECAY_FLOOR_RST;
    phase_acc_m      = 32'd0;
    amp_m            = 25'sd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_registers();
    test_register_extremes();
    test_random_voices();
    test_input_backpressure();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dsv_pkg.sv
rtl/decaying_sine_voice_top.sv
sim/decaying_sine_voice_top_tb.sv
